// ----- hdl/svg_pkg.sv -----
`default_nettype none
package svg_pkg;
	localparam int RADIUS_W = 16;
	localparam int ANG_W = 16;
	localparam int LEN_W = 17;
	localparam int SEG_W = 9;
	localparam int POS_W = 17;
	localparam int NORM_W = 16;
	localparam int IDX_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS       = 3'd0,
		REG_PHI_START    = 3'd1,
		REG_PHI_LENGTH   = 3'd2,
		REG_THETA_START  = 3'd3,
		REG_THETA_LENGTH = 3'd4,
		REG_WIDTH_SEG    = 3'd5,
		REG_HEIGHT_SEG   = 3'd6
	} cfg_reg_t;

	// Taylor coefficients of sin(pi/2*f), Q30
	localparam logic [30:0] C1 = 31'd1686629713;
	localparam logic [30:0] C3 = 31'd693598669;
	localparam logic [30:0] C5 = 31'd85569306;
	localparam logic [30:0] C7 = 31'd5026995;
	localparam logic [30:0] C9 = 31'd172272;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
endpackage
`default_nettype wire

// ----- hdl/svg_if.sv -----
`default_nettype none
interface svg_grid_if;
	logic       valid;
	logic       ready;
	logic [8:0] column;
	logic [8:0] row;
	modport source (output valid, column, row, input ready);
	modport sink (input valid, column, row, output ready);
endinterface

interface svg_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [16:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic [16:0]        vertex_index;
	modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		vertex_index, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		vertex_index, output ready);
endinterface

interface svg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sphere_vertex_generator_top.sv -----
`default_nettype none
// Throughput: one grid point per cycle; the pipeline advances in lockstep with
// the output register and stalls as a whole when the output is valid and the vertex sink holds ready low.
// Reset (arst_n low, asynchronous) clears all valid bits and loads register defaults.
module sphere_vertex_generator_top
	import svg_pkg::*;
#(
	parameter int MAX_SEGMENTS = 256,
	parameter int ANGLE_BITS = 16
) (
	input wire clk,
	input wire arst_n,
	svg_grid_if.sink grid,
	svg_cfg_if.sink cfg,
	svg_vertex_if.source vertex
);
	localparam int NST = 18;
	localparam int SW = $clog2(MAX_SEGMENTS + 1) + 1;
	localparam int NUM_W = SEG_W + LEN_W + 1;
	localparam int RECIP_SH = 40;
	localparam int RW = RECIP_SH + 1;
	localparam int RLO_W = RW / 2;
	localparam int RHI_W = RW - RLO_W;
	localparam int FW = ANGLE_BITS - 2;

	// Configuration registers
	logic [RADIUS_W-1:0] radius_q;
	logic [ANG_W-1:0]    phi_start_q, theta_start_q;
	logic [LEN_W-1:0]    phi_length_q, theta_length_q;
	logic [SEG_W-1:0]    width_seg_q, height_seg_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			phi_start_q <= '0;
			phi_length_q <= 17'd65536;
			theta_start_q <= '0;
			theta_length_q <= 17'd32768;
			width_seg_q <= 9'd32;
			height_seg_q <= 9'd16;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_RADIUS:       radius_q <= cfg.data[RADIUS_W-1:0];
				REG_PHI_START:    phi_start_q <= cfg.data[ANG_W-1:0];
				REG_PHI_LENGTH:   phi_length_q <= cfg.data;
				REG_THETA_START:  theta_start_q <= cfg.data[ANG_W-1:0];
				REG_THETA_LENGTH: theta_length_q <= cfg.data;
				REG_WIDTH_SEG:    width_seg_q <= cfg.data[SEG_W-1:0];
				REG_HEIGHT_SEG:   height_seg_q <= cfg.data[SEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped segment counts and their reciprocals, held static between writes.
	function automatic logic [SW-1:0] clamp_seg(input logic [SEG_W-1:0] s);
		logic [SW-1:0] v;
		v = SW'(s);
		if (v == '0) return SW'(1);
		if (v > SW'(MAX_SEGMENTS)) return SW'(MAX_SEGMENTS);
		return v;
	endfunction

	// floor(2^40/s)+1: exact quotient of n/s for n below 2^27, s up to MAX_SEGMENTS
	function automatic logic [RW-1:0] recip_of(input logic [SW-1:0] s);
		logic [RW-1:0] r;
		r = '0;
		for (int k = 1; k <= MAX_SEGMENTS; k++)
			if (SW'(k) == s) r = RW'(((64'd1 << RECIP_SH) / 64'(k)) + 64'd1);
		return r;
	endfunction

	logic [SW-1:0] ws, hs;
	logic [RW-1:0] ws_rcp, hs_rcp;
	assign ws = clamp_seg(width_seg_q);
	assign hs = clamp_seg(height_seg_q);
	assign ws_rcp = recip_of(ws);
	assign hs_rcp = recip_of(hs);

	// Pipeline control: whole pipe advances unless the output is stalled.
	logic adv;
	logic [NST-1:0] v_s;
	assign adv = !v_s[NST-1] || vertex.ready;
	assign grid.ready = adv;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[NST-2:0], grid.valid};
	end

	// Stage 1: numerators k*len + seg/2, and vertex index
	logic [NUM_W-1:0] pn_s1, tn_s1;
	logic [IDX_W-1:0] idx_s1;
	// Stage 2: quotient by reciprocal multiply, split into low and high partial products
	logic [NUM_W+RLO_W-1:0] pql_s2, tql_s2;
	logic [NUM_W+RHI_W-1:0] pqh_s2, tqh_s2;
	logic [NUM_W+RW-1:0]    pq_sum, tq_sum;
	// Stage 3: angles
	logic [ANGLE_BITS-1:0] phi_s3, th_s3;

	assign pq_sum = {pqh_s2, {RLO_W{1'b0}}} + (NUM_W+RW)'(pql_s2);
	assign tq_sum = {tqh_s2, {RLO_W{1'b0}}} + (NUM_W+RW)'(tql_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			pn_s1 <= NUM_W'(grid.column) * NUM_W'(phi_length_q) + NUM_W'(ws >> 1);
			tn_s1 <= NUM_W'(grid.row) * NUM_W'(theta_length_q) + NUM_W'(hs >> 1);
			idx_s1 <= IDX_W'(grid.row * (IDX_W'(ws) + IDX_W'(1)) + IDX_W'(grid.column));
			pql_s2 <= (NUM_W+RLO_W)'(pn_s1) * (NUM_W+RLO_W)'(ws_rcp[RLO_W-1:0]);
			pqh_s2 <= (NUM_W+RHI_W)'(pn_s1) * (NUM_W+RHI_W)'(ws_rcp[RW-1:RLO_W]);
			tql_s2 <= (NUM_W+RLO_W)'(tn_s1) * (NUM_W+RLO_W)'(hs_rcp[RLO_W-1:0]);
			tqh_s2 <= (NUM_W+RHI_W)'(tn_s1) * (NUM_W+RHI_W)'(hs_rcp[RW-1:RLO_W]);
			phi_s3 <= ANGLE_BITS'(phi_start_q) + pq_sum[RECIP_SH +: ANGLE_BITS];
			th_s3 <= ANGLE_BITS'(theta_start_q) + tq_sum[RECIP_SH +: ANGLE_BITS];
		end
	end

	// Four sine units in parallel lanes: sin phi, cos phi, sin theta, cos theta.
	// Lane stages: 4 prep, 5 square, 6 seed, 7..14 Horner, 15 final product, 16 round.
	logic [ANGLE_BITS-1:0] ang_l [4];
	assign ang_l[0] = phi_s3;
	assign ang_l[1] = phi_s3 + ANGLE_BITS'(1 << FW);
	assign ang_l[2] = th_s3;
	assign ang_l[3] = th_s3 + ANGLE_BITS'(1 << FW);

	logic [30:0] x_s4 [4];
	logic        ng_s4 [4];
	logic [30:0] x_s5 [4], x2_s5 [4];
	logic        ng_s5 [4];
	logic [30:0] x_h  [4][9];
	logic [30:0] x2_h [4][9];
	logic [30:0] p_h  [4][9];
	logic        ng_h [4][9];
	logic [61:0] mul_h [4][8];
	logic [61:0] s_s15 [4];
	logic        ng_s15 [4];
	logic signed [16:0] trig_s16 [4];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [FW-1:0] f;
		logic [30:0] xr;
		logic [31:0] s30;
		logic [16:0] sr;
		assign f = ang_l[l][FW-1:0];
		always_comb begin
			xr = 31'(f) << (30 - FW);
			if (ang_l[l][FW]) xr = ONE_Q30 - xr;
		end
		// Horner products: even steps multiply, odd steps subtract
		for (genvar h = 0; h < 8; h++) begin : g_h
			assign mul_h[l][h] = 62'(x2_h[l][h]) * 62'(p_h[l][h]);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				x_s4[l] <= xr;
				ng_s4[l] <= ang_l[l][ANGLE_BITS-1];
				x_s5[l] <= x_s4[l];
				x2_s5[l] <= 31'((62'(x_s4[l]) * 62'(x_s4[l])) >> 30);
				ng_s5[l] <= ng_s4[l];
				// seed p = C9
				x_h[l][0] <= x_s5[l];
				x2_h[l][0] <= x2_s5[l];
				p_h[l][0] <= C9;
				ng_h[l][0] <= ng_s5[l];
				for (int h = 0; h < 8; h++) begin
					x_h[l][h+1] <= x_h[l][h];
					x2_h[l][h+1] <= x2_h[l][h];
					ng_h[l][h+1] <= ng_h[l][h];
					if (h % 2 == 0) p_h[l][h+1] <= 31'(mul_h[l][h] >> 30);
					else begin
						case (h)
							1: p_h[l][h+1] <= C7 - p_h[l][h];
							3: p_h[l][h+1] <= C5 - p_h[l][h];
							5: p_h[l][h+1] <= C3 - p_h[l][h];
							default: p_h[l][h+1] <= C1 - p_h[l][h];
						endcase
					end
				end
				s_s15[l] <= 62'(x_h[l][8]) * 62'(p_h[l][8]);
				ng_s15[l] <= ng_h[l][8];
			end
		end
		// round to Q15, cap, sign
		always_comb begin
			s30 = 32'(s_s15[l] >> 30);
			sr = 17'((s30 + 32'd16384) >> 15);
			if (sr > 17'd32768) sr = 17'd32768;
		end
		always_ff @(posedge clk) begin
			if (adv) trig_s16[l] <= ng_s15[l] ? -$signed(sr) : $signed(sr);
		end
	end

	// Carry the vertex index alongside the trig lanes
	logic [IDX_W-1:0] idx_d [NST];
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_d[2] <= idx_s1;
			for (int i = 3; i < NST; i++) idx_d[i] <= idx_d[i-1];
		end
	end

	// Stage 17: magnitudes of products; stage 18: scale by radius, round, sign.
	logic [31:0] cs_s17, ss_s17;
	logic [15:0] ct_s17;
	logic        nx_neg_s17, nz_neg_s17, y_neg_s17;
	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s17 <= 32'(trig_s16[1][16] ? -trig_s16[1] : trig_s16[1]) *
				32'(trig_s16[2][16] ? -trig_s16[2] : trig_s16[2]);
			ss_s17 <= 32'(trig_s16[0][16] ? -trig_s16[0] : trig_s16[0]) *
				32'(trig_s16[2][16] ? -trig_s16[2] : trig_s16[2]);
			ct_s17 <= 16'(trig_s16[3][16] ? -trig_s16[3] : trig_s16[3]);
			y_neg_s17 <= trig_s16[3][16];
			// x carries the extra minus sign
			nx_neg_s17 <= !(trig_s16[1][16] ^ trig_s16[2][16]);
			nz_neg_s17 <= trig_s16[0][16] ^ trig_s16[2][16];
		end
	end

	logic [47:0] px_m, pz_m;
	logic [31:0] py_m;
	logic [16:0] nx_m, nz_m;
	always_comb begin
		px_m = (48'(cs_s17) * 48'(radius_q) + 48'(1 << 29)) >> 30;
		pz_m = (48'(ss_s17) * 48'(radius_q) + 48'(1 << 29)) >> 30;
		py_m = (32'(ct_s17) * 32'(radius_q) + 32'(1 << 14)) >> 15;
		nx_m = 17'((cs_s17 + 32'(1 << 14)) >> 15);
		nz_m = 17'((ss_s17 + 32'(1 << 14)) >> 15);
	end

	function automatic logic signed [15:0] sat_n(input logic [16:0] m, input logic neg);
		if (neg) return 16'(-$signed({1'b0, m}));
		if (m > 17'd32767) return 16'sd32767;
		return 16'(m);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			vertex.pos_x <= nx_neg_s17 ? -$signed(17'(px_m)) : $signed(17'(px_m));
			vertex.pos_z <= nz_neg_s17 ? -$signed(17'(pz_m)) : $signed(17'(pz_m));
			vertex.pos_y <= y_neg_s17 ? -$signed(17'(py_m)) : $signed(17'(py_m));
			vertex.norm_x <= (radius_q == '0) ? '0 : sat_n(nx_m, nx_neg_s17);
			vertex.norm_z <= (radius_q == '0) ? '0 : sat_n(nz_m, nz_neg_s17);
			vertex.norm_y <= (radius_q == '0) ? '0 : sat_n({1'b0, ct_s17}, y_neg_s17);
			vertex.vertex_index <= idx_d[NST-1];
		end
	end
	assign vertex.valid = v_s[NST-1];

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && !vertex.ready |=> vertex.valid && $stable(vertex.vertex_index))
		else $error("output changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vertex.valid |-> grid.ready)
		else $error("input blocked with empty output");
	a_zero_r: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && radius_q == '0 |-> vertex.norm_y == '0)
		else $error("nonzero normal at zero radius");
`endif
endmodule
`default_nettype wire
